### design/mdbcc_pkg.sv
// ----------------------------------------------------------------------------
// mdbcc_pkg
// shared types, constants and tables of the coin changer peripheral
// ----------------------------------------------------------------------------
package mdbcc_pkg;

    localparam int unsigned RING_DEPTH_DEF     = 32;
    localparam int unsigned POLL_REPLY_MAX_DEF = 16;

    localparam logic [7:0] WORD_ACK    = 8'h00;
    localparam logic [7:0] WORD_RET    = 8'hAA;
    localparam logic [7:0] WORD_NAK    = 8'hFF;
    localparam logic [7:0] EVT_DEPOSIT = 8'h40;
    localparam logic [7:0] EVT_CLASS   = 8'hC0;
    localparam logic [7:0] EVT_RESET   = 8'h0B;
    localparam logic [7:0] LEVEL3      = 8'h03;

    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_DISABLED = 2'd1;
    localparam logic [1:0] MODE_ENABLED  = 2'd2;

    localparam logic [2:0] CMD_RESET  = 3'd0;
    localparam logic [2:0] CMD_SETUP  = 3'd1;
    localparam logic [2:0] CMD_TUBE   = 3'd2;
    localparam logic [2:0] CMD_POLL   = 3'd3;
    localparam logic [2:0] CMD_COIN   = 3'd4;
    localparam logic [2:0] CMD_DISP   = 3'd5;
    localparam logic [2:0] CMD_NONE   = 3'd6;
    localparam logic [2:0] CMD_EXP    = 3'd7;

    localparam logic [2:0] CFG_ADDR   = 3'd0;
    localparam logic [2:0] CFG_CAP    = 3'd1;
    localparam logic [2:0] CFG_CUR    = 3'd2;
    localparam logic [2:0] CFG_SCALE  = 3'd3;
    localparam logic [2:0] CFG_DEC    = 3'd4;
    localparam logic [2:0] CFG_CREDIT = 3'd5;
    localparam logic [2:0] CFG_ROUTE  = 3'd6;
    localparam logic [2:0] CFG_BTYPE  = 3'd7;

    localparam logic [2:0] SRC_SETUP = 3'd0;
    localparam logic [2:0] SRC_TUBE  = 3'd1;
    localparam logic [2:0] SRC_ID    = 3'd2;
    localparam logic [2:0] SRC_RST   = 3'd3;
    localparam logic [2:0] SRC_RING  = 3'd4;
    localparam logic [2:0] SRC_ZERO  = 3'd5;

    typedef struct packed {
        logic       action;
        logic [8:0] bus_word;
    } t_in;

    typedef struct packed {
        logic [8:0] tx_word;
        logic       last_word;
    } t_out;

    typedef struct packed {
        logic       in_take;
        logic       exec_op;
        logic       rr_clr;
        logic       dep_a;
        logic       dep_b;
        logic       scan;
        logic       pop;
        logic       emit;
        logic       emit_sum;
        logic [2:0] src;
        logic [5:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       exec_now;
        logic [2:0] cmd;
        logic       sub0;
        logic       pending_nz;
        logic       dep_ok;
        logic       rr_pend;
        logic       ring_empty;
        logic       pop_dep;
        logic       out_free;
    } t_sts;

    function automatic logic [7:0] id_byte(input logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 6'd0) b = 8'h4D;
        else if (idx == 6'd1) b = 8'h44;
        else if (idx == 6'd2) b = 8'h42;
        else if (idx >= 6'd3 && idx <= 6'd26) b = 8'h20;
        else if (idx == 6'd28) b = 8'h01;
        return b;
    endfunction

endpackage

### design/mdbcc_ctrl.sv
// ----------------------------------------------------------------------------
// mdbcc_ctrl
// frame execution sequencer: reply byte loops, deposit loop and poll popping
// ----------------------------------------------------------------------------
module mdbcc_ctrl #(
    parameter int unsigned POLL_REPLY_MAX = mdbcc_pkg::POLL_REPLY_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mdbcc_pkg::t_sts  i_sts,
    output mdbcc_pkg::t_cmd  o_cmd
);
    import mdbcc_pkg::*;

    localparam int unsigned NW = $clog2(POLL_REPLY_MAX + 1);
    localparam logic [NW-1:0] N_LIM1 = NW'(POLL_REPLY_MAX - 1);
    localparam logic [NW-1:0] N_LIM  = NW'(POLL_REPLY_MAX);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_EMIT  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DEP   = 4'd5;
    localparam logic [3:0] S_DEP2  = 4'd6;
    localparam logic [3:0] S_PDEC  = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_PEMIT = 4'd9;
    localparam logic [3:0] S_PFOL  = 4'd10;
    localparam logic [3:0] S_PEMI2 = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [5:0]    r_idx, n_idx;
    logic [5:0]    r_len, n_len;
    logic [2:0]    r_src, n_src;
    logic [NW-1:0] r_n, n_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_len   <= '0;
            r_src   <= SRC_ZERO;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_src   <= n_src;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        n_src   = r_src;
        n_n     = r_n;
        o_cmd   = '0;
        o_cmd.src = r_src;
        o_cmd.idx = r_idx;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.in_take = i_in_valid;
                if (i_in_valid && i_sts.exec_now) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec_op = 1'b1;
                n_idx = '0;
                case (i_sts.cmd)
                    CMD_SETUP: begin
                        n_src = SRC_SETUP; n_len = 6'd23; n_state = S_EMIT;
                    end
                    CMD_TUBE: n_state = S_SCAN;
                    CMD_POLL: n_state = S_DEP;
                    CMD_EXP: begin
                        if (i_sts.sub0) begin
                            n_src = SRC_ID; n_len = 6'd33; n_state = S_EMIT;
                        end else begin
                            n_state = S_SUM;
                        end
                    end
                    default: n_state = S_SUM;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_idx == 6'd15) begin
                    n_idx = '0; n_src = SRC_TUBE; n_len = 6'd18; n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == r_len - 6'd1) begin
                        n_idx = '0; n_state = S_SUM;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DEP: begin
                if (i_sts.pending_nz) begin
                    o_cmd.dep_a = 1'b1;
                    if (i_sts.dep_ok) n_state = S_DEP2;
                end else begin
                    n_state = S_PDEC;
                end
            end
            S_DEP2: begin
                o_cmd.dep_b = 1'b1;
                n_state = S_DEP;
            end
            S_PDEC: begin
                n_n = '0;
                if (i_sts.rr_pend) begin
                    o_cmd.rr_clr = 1'b1;
                    n_idx = '0; n_src = SRC_RST; n_len = 6'd1; n_state = S_EMIT;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (!i_sts.ring_empty && r_n < N_LIM1) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_PEMIT;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_PEMIT: begin
                o_cmd.src = SRC_RING;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_n = r_n + NW'(1);
                    n_state = i_sts.pop_dep ? S_PFOL : S_PCHK;
                end
            end
            S_PFOL: begin
                if (!i_sts.ring_empty && r_n < N_LIM) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_PEMI2;
                end else begin
                    o_cmd.src = SRC_ZERO;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_n = r_n + NW'(1);
                        n_state = S_PCHK;
                    end
                end
            end
            S_PEMI2: begin
                o_cmd.src = SRC_RING;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_n = r_n + NW'(1);
                    n_state = S_PCHK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### design/mdbcc_dp.sv
// ----------------------------------------------------------------------------
// mdbcc_dp
// frame receiver, changer state, tube counts, event ring and reply register
// ----------------------------------------------------------------------------
module mdbcc_dp #(
    parameter int unsigned RING_DEPTH = mdbcc_pkg::RING_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mdbcc_pkg::t_in   i_in,
    input  logic             i_cfg_valid,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  mdbcc_pkg::t_cmd  i_cmd,
    output mdbcc_pkg::t_sts  o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mdbcc_pkg::t_out  o_out
);
    import mdbcc_pkg::*;

    localparam int unsigned RW = $clog2(RING_DEPTH);
    localparam logic [RW-1:0] R_LAST = RW'(RING_DEPTH - 1);

    // configuration
    logic [4:0]  r_addr;
    logic [7:0]  r_cap, r_scale, r_dec;
    logic [15:0] r_cur, r_route;
    logic [63:0] r_credit;
    logic [3:0]  r_btype;

    // changer state
    logic [1:0]  r_mode;
    logic        r_rr;
    logic [15:0] r_cen, r_den, r_full;
    logic [7:0]  r_tube [16];
    logic [7:0]  r_pend;
    logic [2:0]  r_phase, r_ccmd;
    logic [7:0]  r_csum, r_sum;
    logic [7:0]  r_cb [5];
    logic [7:0]  r_ring [RING_DEPTH];
    logic [RW-1:0] r_head, r_tail;
    logic [7:0]  r_rd_data;
    logic        r_out_valid;
    t_out        r_out;

    logic [7:0]  lo;
    logic [2:0]  got;
    logic [2:0]  need;
    logic        hit, data_ok;
    logic [3:0]  taddr;
    logic [7:0]  tval;
    logic        route;
    logic        push_en;
    logic [7:0]  push_val;
    logic [RW-1:0] head_nx, tail_nx;
    logic [7:0]  byte_v;
    logic [5:0]  im2, im7;
    logic [3:0]  dcnt;

    assign lo  = i_in.bus_word[7:0];
    assign got = r_phase - 3'd1;

    always_comb begin
        case (r_ccmd)
            CMD_COIN: need = 3'd4;
            CMD_DISP: need = 3'd1;
            CMD_EXP:  need = (r_phase >= 3'd2 && r_cb[0] == 8'd1) ? 3'd5 : 3'd1;
            default:  need = 3'd0;
        endcase
    end

    assign hit = i_in.bus_word[8] && lo != WORD_ACK && lo != WORD_RET && lo != WORD_NAK
                 && lo[7:3] == r_addr && lo[2:0] != CMD_NONE;
    assign data_ok = (got < need);

    assign im2 = i_cmd.idx - 6'd2;
    assign im7 = i_cmd.idx - 6'd7;
    assign dcnt = r_cb[0][7:4];

    always_comb begin
        if (i_cmd.scan) taddr = i_cmd.idx[3:0];
        else if (i_cmd.emit) taddr = im2[3:0];
        else if (i_cmd.dep_a || i_cmd.dep_b) taddr = r_btype;
        else taddr = r_cb[0][3:0];
    end
    assign tval  = r_tube[taddr];
    assign route = (tval < r_cap);

    assign head_nx = (r_head == R_LAST) ? '0 : r_head + RW'(1);
    assign tail_nx = (r_tail == R_LAST) ? '0 : r_tail + RW'(1);

    always_comb begin
        push_en  = 1'b0;
        push_val = tval;
        if (i_cmd.dep_a && o_sts.dep_ok) begin
            push_en  = 1'b1;
            push_val = EVT_DEPOSIT | {3'b000, route, r_btype};
        end else if (i_cmd.dep_b) begin
            push_en = 1'b1;
        end
    end

    always_comb begin
        byte_v = 8'h00;
        case (i_cmd.src)
            SRC_SETUP: begin
                case (i_cmd.idx)
                    6'd0: byte_v = LEVEL3;
                    6'd1: byte_v = r_cur[15:8];
                    6'd2: byte_v = r_cur[7:0];
                    6'd3: byte_v = r_scale;
                    6'd4: byte_v = r_dec;
                    6'd5: byte_v = r_route[15:8];
                    6'd6: byte_v = r_route[7:0];
                    default: byte_v = (i_cmd.idx <= 6'd14) ? r_credit[{im7[2:0], 3'b000} +: 8]
                                                          : 8'h00;
                endcase
            end
            SRC_TUBE: begin
                if (i_cmd.idx == 6'd0) byte_v = r_full[15:8];
                else if (i_cmd.idx == 6'd1) byte_v = r_full[7:0];
                else byte_v = tval;
            end
            SRC_ID:   byte_v = id_byte(i_cmd.idx);
            SRC_RST:  byte_v = EVT_RESET;
            SRC_RING: byte_v = r_rd_data;
            default:  byte_v = 8'h00;
        endcase
    end

    always_comb begin
        o_sts.exec_now   = !i_in.action && r_phase != 3'd0 && !data_ok
                           && i_in.bus_word == {1'b0, r_csum};
        o_sts.cmd        = r_ccmd;
        o_sts.sub0       = (r_cb[0] == 8'd0);
        o_sts.pending_nz = (r_pend != 8'd0);
        o_sts.dep_ok     = (r_mode == MODE_ENABLED) && r_cen[r_btype];
        o_sts.rr_pend    = r_rr;
        o_sts.ring_empty = (r_head == r_tail);
        o_sts.pop_dep    = ((r_rd_data & EVT_CLASS) == EVT_DEPOSIT);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 5'd1; r_cap <= 8'd100; r_cur <= 16'hFFFF; r_scale <= 8'd1;
            r_dec <= 8'd2; r_credit <= 64'd6581509; r_route <= 16'd15; r_btype <= 4'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ADDR:   r_addr   <= i_cfg_data[4:0];
                CFG_CAP:    r_cap    <= i_cfg_data[7:0];
                CFG_CUR:    r_cur    <= i_cfg_data[15:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[7:0];
                CFG_DEC:    r_dec    <= i_cfg_data[7:0];
                CFG_CREDIT: r_credit <= i_cfg_data;
                CFG_ROUTE:  r_route  <= i_cfg_data[15:0];
                CFG_BTYPE:  r_btype  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_INACTIVE; r_rr <= 1'b0; r_cen <= '0; r_den <= '0;
            r_pend <= '0; r_phase <= '0; r_ccmd <= '0; r_csum <= '0; r_sum <= '0;
            r_head <= '0; r_tail <= '0; r_out_valid <= 1'b0; r_full <= '0;
            for (int i = 0; i < 16; i++) r_tube[i] <= '0;
            for (int i = 0; i < 5; i++) r_cb[i] <= '0;
        end else begin
            if (i_cmd.in_take) begin
                if (i_in.action) begin
                    if (r_pend != 8'hFF) r_pend <= r_pend + 8'd1;
                end else if (r_phase == 3'd0) begin
                    if (hit) begin
                        r_ccmd  <= lo[2:0];
                        r_csum  <= lo;
                        r_phase <= 3'd1;
                        for (int i = 0; i < 5; i++) r_cb[i] <= '0;
                    end
                end else if (data_ok) begin
                    r_cb[got] <= lo;
                    r_csum    <= r_csum + lo;
                    if (r_ccmd == CMD_EXP && got == 3'd0 && lo > 8'd1) r_phase <= 3'd0;
                    else r_phase <= r_phase + 3'd1;
                end else begin
                    r_phase <= 3'd0;
                end
            end
            if (i_cmd.exec_op) begin
                case (r_ccmd)
                    CMD_RESET: begin
                        r_rr <= 1'b1; r_mode <= MODE_INACTIVE; r_cen <= '0; r_den <= '0;
                    end
                    CMD_SETUP: r_mode <= MODE_DISABLED;
                    CMD_COIN: begin
                        r_cen  <= {r_cb[0], r_cb[1]};
                        r_den  <= {r_cb[2], r_cb[3]};
                        r_mode <= ({r_cb[0], r_cb[1]} != 16'd0) ? MODE_ENABLED : MODE_DISABLED;
                    end
                    CMD_DISP: begin
                        if (tval >= {4'd0, dcnt}) r_tube[taddr] <= tval - {4'd0, dcnt};
                    end
                    default: ;
                endcase
            end
            if (i_cmd.rr_clr) begin
                r_rr <= 1'b0; r_mode <= MODE_DISABLED;
            end
            if (i_cmd.scan) r_full[taddr] <= !route;
            if (i_cmd.dep_a) begin
                r_pend <= r_pend - 8'd1;
                if (o_sts.dep_ok && route) r_tube[taddr] <= tval + 8'd1;
            end
            if (push_en && head_nx != r_tail) r_head <= head_nx;
            if (i_cmd.pop) r_tail <= tail_nx;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_sum <= r_sum + byte_v;
            end else if (i_cmd.emit_sum) begin
                r_out_valid <= 1'b1;
                r_sum <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en && head_nx != r_tail) r_ring[r_head] <= push_val;
        if (i_cmd.pop) r_rd_data <= r_ring[r_tail];
        if (i_cmd.emit) begin
            r_out.tx_word   <= {1'b0, byte_v};
            r_out.last_word <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            r_out.tx_word   <= {1'b1, r_sum};
            r_out.last_word <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### design/mdb_coin_changer_peripheral.sv
// ----------------------------------------------------------------------------
// mdb_coin_changer_peripheral
// coin changer bus slave: frame check, command execution and replies
// input: a bus word or button beat is taken while idle; a frame's reply follows its
// checksum beat via the execute state, tube status after a scan of all 16 tubes
// throughput: one beat a cycle while idle; replies one word a cycle unless the output
// stalls; a poll instead pops, then emits, each ring byte after its pending coins
// reset: synchronous active low, clears control state; the ring contents need no clear
// ----------------------------------------------------------------------------
module mdb_coin_changer_peripheral #(
    parameter int unsigned RING_DEPTH     = mdbcc_pkg::RING_DEPTH_DEF,
    parameter int unsigned POLL_REPLY_MAX = mdbcc_pkg::POLL_REPLY_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mdbcc_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mdbcc_pkg::t_out  o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data
);
    import mdbcc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mdbcc_ctrl #(.POLL_REPLY_MAX(POLL_REPLY_MAX)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mdbcc_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_last_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last_word |-> o_out.tx_word[8])
        else $error("last word without mode bit");

    a_data_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_word |-> !o_out.tx_word[8])
        else $error("data word with mode bit");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.emit && cmd.emit_sum))
        else $error("two loads of the reply register");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit || cmd.emit_sum |-> !o_in_ready)
        else $error("input ready while replying");

endmodule

### dv/mdb_coin_changer_peripheral_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_coin_changer_peripheral_tb
// drives bus words, button presses and register writes into the coin changer,
// predicts every reply word from its own model of the slave and checks each
// transmitted beat in order, with random idling and back-pressure on both sides
// ----------------------------------------------------------------------------
module mdb_coin_changer_peripheral_tb;
    import mdbcc_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_pay = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_ADDR;
    logic [63:0] cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out        o_out;

    mdb_coin_changer_peripheral dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in(in_pay),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out(o_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // changer model
    logic [4:0]  m_addr = 5'd1;
    logic [7:0]  m_cap = 8'd100, m_scale = 8'd1, m_dec = 8'd2;
    logic [15:0] m_cur = 16'hFFFF, m_route = 16'd15;
    logic [63:0] m_credit = 64'd6581509;
    logic [3:0]  m_btype = 4'd2;
    logic [1:0]  chg_mode = MODE_INACTIVE;
    logic        rst_report = 1'b0;
    logic [15:0] coin_en = '0, disp_en = '0;
    logic [7:0]  tubes [16];
    logic [7:0]  ring [RING_DEPTH_DEF];
    int          r_head = 0, r_tail = 0;
    logic [7:0]  pend_coins = '0;
    int          rx_phase = 0;
    logic [2:0]  cur_cmd = CMD_RESET;
    logic [7:0]  csum = '0;
    logic [39:0] cmd_b = '0;

    t_out reply_q [$];
    int   errors = 0;
    int   items = 0;
    int   rx_hold = 0;
    bit   no_idle = 0;
    int   quiet = 0;

    initial for (int i = 0; i < 16; i++) tubes[i] = '0;

    function automatic void ring_push(input logic [7:0] v);
        int nx;
        nx = (r_head + 1) % RING_DEPTH_DEF;
        if (nx != r_tail) begin
            ring[r_head] = v;
            r_head = nx;
        end
    endfunction

    function automatic logic [7:0] ring_pop();
        logic [7:0] v;
        v = ring[r_tail];
        r_tail = (r_tail + 1) % RING_DEPTH_DEF;
        return v;
    endfunction

    function automatic void deposit_coin();
        logic route;
        route = 1'b0;
        if (chg_mode != MODE_ENABLED || !coin_en[m_btype]) return;
        if (tubes[m_btype] < m_cap) begin
            tubes[m_btype]++;
            route = 1'b1;
        end
        ring_push(EVT_DEPOSIT | {3'b0, route, m_btype});
        ring_push(tubes[m_btype]);
    endfunction

    function automatic int bytes_wanted();
        case (cur_cmd)
            CMD_COIN: return 4;
            CMD_DISP: return 1;
            CMD_EXP:  return (rx_phase >= 2 && cmd_b[7:0] == 8'd1) ? 5 : 1;
            default:  return 0;
        endcase
    endfunction

    function automatic void run_command();
        logic [7:0]  pl [40];
        logic [7:0]  s, b;
        logic [15:0] full;
        int          n;
        n = 0;
        for (int i = 0; i < 40; i++) pl[i] = '0;
        case (cur_cmd)
            CMD_RESET: begin
                rst_report = 1'b1;
                chg_mode = MODE_INACTIVE;
                coin_en = '0;
                disp_en = '0;
            end
            CMD_SETUP: begin
                chg_mode = MODE_DISABLED;
                pl[0] = LEVEL3;
                pl[1] = m_cur[15:8];
                pl[2] = m_cur[7:0];
                pl[3] = m_scale;
                pl[4] = m_dec;
                pl[5] = m_route[15:8];
                pl[6] = m_route[7:0];
                for (int i = 0; i < 8; i++) pl[7 + i] = m_credit[8*i +: 8];
                n = 23;
            end
            CMD_TUBE: begin
                full = '0;
                for (int i = 0; i < 16; i++) full[i] = (tubes[i] >= m_cap);
                pl[0] = full[15:8];
                pl[1] = full[7:0];
                for (int i = 0; i < 16; i++) pl[2 + i] = tubes[i];
                n = 18;
            end
            CMD_POLL: begin
                while (pend_coins != 0) begin
                    pend_coins--;
                    deposit_coin();
                end
                if (rst_report) begin
                    rst_report = 1'b0;
                    chg_mode = MODE_DISABLED;
                    pl[0] = EVT_RESET;
                    n = 1;
                end else begin
                    while (r_head != r_tail && n < POLL_REPLY_MAX_DEF - 1) begin
                        b = ring_pop();
                        pl[n] = b;
                        n++;
                        if ((b & EVT_CLASS) == EVT_DEPOSIT) begin
                            pl[n] = (r_head != r_tail) ? ring_pop() : 8'h00;
                            n++;
                        end
                    end
                end
            end
            CMD_COIN: begin
                coin_en = {cmd_b[7:0], cmd_b[15:8]};
                disp_en = {cmd_b[23:16], cmd_b[31:24]};
                chg_mode = (coin_en != 0) ? MODE_ENABLED : MODE_DISABLED;
            end
            CMD_DISP: begin
                if (tubes[cmd_b[3:0]] >= {4'b0, cmd_b[7:4]})
                    tubes[cmd_b[3:0]] = tubes[cmd_b[3:0]] - {4'b0, cmd_b[7:4]};
            end
            CMD_EXP: begin
                if (cmd_b[7:0] == 8'd0) begin
                    pl[0] = 8'h4D;
                    pl[1] = 8'h44;
                    pl[2] = 8'h42;
                    for (int i = 3; i < 27; i++) pl[i] = 8'h20;
                    pl[28] = 8'h01;
                    n = 33;
                end
            end
            default: return;
        endcase
        s = '0;
        for (int i = 0; i < n; i++) begin
            s += pl[i];
            reply_q.push_back('{tx_word: {1'b0, pl[i]}, last_word: 1'b0});
        end
        reply_q.push_back('{tx_word: {1'b1, s}, last_word: 1'b1});
    endfunction

    function automatic void predict_beat(input t_in it);
        logic [7:0] lo;
        int         got;
        lo = it.bus_word[7:0];
        if (it.action) begin
            if (pend_coins != 8'hFF) pend_coins++;
            return;
        end
        if (rx_phase == 0) begin
            if (!it.bus_word[8]) return;
            if (lo == WORD_ACK || lo == WORD_RET || lo == WORD_NAK) return;
            if (lo[7:3] != m_addr || lo[2:0] == CMD_NONE) return;
            cur_cmd = lo[2:0];
            csum = lo;
            cmd_b = '0;
            rx_phase = 1;
            return;
        end
        got = (rx_phase - 1) & 7;
        if (got < bytes_wanted()) begin
            cmd_b[8*got +: 8] = lo;
            csum += lo;
            rx_phase++;
            if (cur_cmd == CMD_EXP && got == 0 && lo > 8'd1) rx_phase = 0;
            return;
        end
        rx_phase = 0;
        if (it.bus_word == {1'b0, csum}) run_command();
    endfunction

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // sender
    task automatic send_beat(input logic act, input logic [8:0] w);
        int gap;
        bit ok;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pay <= '{action: act, bus_word: w};
        do begin
            @(negedge i_clk);
            ok = o_in_ready;
            @(posedge i_clk);
        end while (!ok);
        predict_beat(in_pay);
        items++;
    endtask

    task automatic send_frame(input logic [2:0] cmd, input logic [39:0] data, input int nb,
                              input bit good);
        logic [7:0] s;
        s = {m_addr, cmd};
        send_beat(1'b0, {1'b1, s});
        for (int i = 0; i < nb; i++) begin
            send_beat(1'b0, {1'b0, data[8*i +: 8]});
            s += data[8*i +: 8];
        end
        if (good)
            send_beat(1'b0, {1'b0, s});
        else if ($urandom_range(0, 1))
            send_beat(1'b0, {1'b1, s});
        else
            send_beat(1'b0, {1'b0, s ^ (8'h01 << $urandom_range(0, 7))});
    endtask

    task automatic press(input int k);
        for (int i = 0; i < k; i++) send_beat(1'b1, 9'($urandom_range(0, 511)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
        bit ok;
        wait_drained();
        repeat (60) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ADDR:   m_addr = v[4:0];
            CFG_CAP:    m_cap = v[7:0];
            CFG_CUR:    m_cur = v[15:0];
            CFG_SCALE:  m_scale = v[7:0];
            CFG_DEC:    m_dec = v[7:0];
            CFG_CREDIT: m_credit = v;
            CFG_ROUTE:  m_route = v[15:0];
            default:    m_btype = v[3:0];
        endcase
    endtask

    // receiver and checker
    initial begin
        int   stall;
        bit   got;
        t_out beat, want;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else
                stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                got = o_out_valid;
                beat = o_out;
                @(posedge i_clk);
            end while (!got);
            if (reply_q.size() == 0)
                report($sformatf("unexpected word %h", beat.tx_word));
            else begin
                want = reply_q.pop_front();
                if (beat.tx_word !== want.tx_word)
                    report($sformatf("tx_word %h, want %h", beat.tx_word, want.tx_word));
                if (beat.last_word !== want.last_word)
                    report($sformatf("last_word %b, want %b", beat.last_word, want.last_word));
            end
        end
    end

    always @(negedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            quiet <= 0;
        else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("mdb_coin_changer_peripheral verification failed");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    task automatic test_idle_words();
        send_beat(1'b0, {1'b1, WORD_ACK});
        send_beat(1'b0, {1'b1, WORD_RET});
        send_beat(1'b0, {1'b1, WORD_NAK});
        send_beat(1'b0, {1'b0, m_addr, CMD_SETUP});
        send_beat(1'b0, {1'b1, m_addr + 5'd1, CMD_SETUP});
        send_beat(1'b0, {1'b1, m_addr, CMD_NONE});
    endtask

    task automatic test_commands();
        send_frame(CMD_RESET, '0, 0, 1);
        send_frame(CMD_POLL, '0, 0, 1);
        send_frame(CMD_SETUP, '0, 0, 1);
        send_frame(CMD_COIN, 40'hFF_FF_FF_FF, 4, 1);
        press(3);
        send_frame(CMD_POLL, '0, 0, 1);
        send_frame(CMD_TUBE, '0, 0, 1);
        send_frame(CMD_DISP, 40'h12, 1, 1);
        send_frame(CMD_DISP, 40'hF2, 1, 1);
        send_frame(CMD_EXP, 40'h00, 1, 1);
        send_frame(CMD_EXP, 40'h1_2345_6701, 5, 1);
        send_frame(CMD_EXP, 40'h02, 1, 1);
        send_frame(CMD_SETUP, '0, 0, 0);
        send_frame(CMD_COIN, 40'h00_00_00_00, 4, 1);
        send_frame(CMD_COIN, 40'hFF_FF_FF_FF, 4, 1);
    endtask

    task automatic test_ring_and_saturation();
        no_idle = 1;
        press(256);
        no_idle = 0;
        send_frame(CMD_POLL, '0, 0, 1);
        send_frame(CMD_TUBE, '0, 0, 1);
        for (int i = 0; i < 4; i++) send_frame(CMD_POLL, '0, 0, 1);
    endtask

    task automatic test_config();
        cfg_write(CFG_ADDR, 64'd31);
        cfg_write(CFG_CAP, 64'd0);
        cfg_write(CFG_CUR, 64'd0);
        cfg_write(CFG_SCALE, 64'd255);
        cfg_write(CFG_DEC, 64'd0);
        cfg_write(CFG_CREDIT, '1);
        cfg_write(CFG_ROUTE, 64'd0);
        cfg_write(CFG_BTYPE, 64'd15);
        send_frame(CMD_SETUP, '0, 0, 1);
        send_frame(CMD_COIN, 40'h00_00_80_00, 4, 1);
        press(2);
        send_frame(CMD_POLL, '0, 0, 1);
        send_frame(CMD_TUBE, '0, 0, 1);
        send_beat(1'b0, {1'b1, 5'd31, CMD_EXP});
        cfg_write(CFG_ADDR, 64'd0);
        cfg_write(CFG_CAP, 64'd255);
        cfg_write(CFG_CUR, 64'hFFFF);
        cfg_write(CFG_SCALE, 64'd0);
        cfg_write(CFG_DEC, 64'd255);
        cfg_write(CFG_CREDIT, {$urandom, $urandom});
        cfg_write(CFG_ROUTE, 64'hFFFF);
        cfg_write(CFG_BTYPE, 64'd0);
        send_frame(CMD_SETUP, '0, 0, 1);
        send_frame(CMD_COIN, 40'h00_00_00_01, 4, 1);
        press(2);
        send_frame(CMD_POLL, '0, 0, 1);
        send_frame(CMD_TUBE, '0, 0, 1);
        cfg_write(CFG_ADDR, 64'd1);
        cfg_write(CFG_CAP, 64'd3);
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        for (int i = 0; i < 6; i++) send_frame(CMD_SETUP, '0, 0, 1);
        send_frame(CMD_EXP, 40'h00, 1, 1);
        wait_drained();
        send_frame(CMD_TUBE, '0, 0, 1);
    endtask

    task automatic random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_frame(CMD_RESET, '0, 0, $urandom_range(0, 9) != 0);
        else if (r < 18)
            send_frame(CMD_SETUP, '0, 0, $urandom_range(0, 9) != 0);
        else if (r < 28)
            send_frame(CMD_TUBE, '0, 0, $urandom_range(0, 9) != 0);
        else if (r < 58)
            send_frame(CMD_POLL, '0, 0, $urandom_range(0, 9) != 0);
        else if (r < 72)
            send_frame(CMD_COIN, {8'h0, 16'($urandom), ($urandom_range(0, 1) ? 16'hFFFF
                       : 16'($urandom))}, 4, $urandom_range(0, 9) != 0);
        else if (r < 86)
            send_frame(CMD_DISP, 40'($urandom_range(0, 255)), 1, $urandom_range(0, 9) != 0);
        else if (r < 92)
            send_frame(CMD_EXP, 40'h00, 1, $urandom_range(0, 9) != 0);
        else if (r < 97)
            send_frame(CMD_EXP, {$urandom, 8'h01}, 5, $urandom_range(0, 9) != 0);
        else
            send_frame(CMD_EXP, 40'($urandom_range(2, 255)), 1, 1);
    endtask

    task automatic test_random(input int count);
        int stop_at, r;
        stop_at = items + count;
        while (items < stop_at) begin
            no_idle = ((items / 40) % 4) == 3;
            r = $urandom_range(0, 99);
            if (r < 18)
                press($urandom_range(1, 4));
            else if (r < 26)
                send_beat(1'b0, 9'($urandom_range(0, 511)));
            else
                random_frame();
        end
        no_idle = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_words();
        test_commands();
        test_ring_and_saturation();
        test_config();
        test_backpressure();
        test_random(12);
        wait_drained();
        cfg_write(CFG_CAP, 64'd100);
        cfg_write(CFG_BTYPE, 64'($urandom_range(0, 15)));
        test_random(8);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && reply_q.size() == 0)
            $display("mdb_coin_changer_peripheral verification clean");
        else
            $display("mdb_coin_changer_peripheral verification failed");
        $finish;
    end

endmodule
